// ===== sv/probe_request_tracker_defines.svh =====
// assertion macros shared by the checker of the probe request tracker
// expects signals named aclk and aresetn in the scope of use
`ifndef PROBE_REQUEST_TRACKER_DEFINES_SVH
`define PROBE_REQUEST_TRACKER_DEFINES_SVH

// same-cycle implication, checked out of reset
`define PRT_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("probe tracker check failed");

// next-cycle implication, checked out of reset
`define PRT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("probe tracker check failed");

`endif

// ===== sv/prt_pkg.sv =====
// types, codes and constants of the probe request tracker
// used by prt_cell, probe_request_tracker and prt_checker; no dependencies
package prt_pkg;

    localparam int TABLE_ENTRIES_DEF = 32;
    localparam int SSID_BITS         = 256;
    localparam int HDR_LEN           = 26;
    localparam int SSID_MAX          = 32;
    localparam int POS_W             = 12;
    localparam logic [11:0] POS_MAX  = 12'd4095;
    localparam logic [7:0] FC_TYPE_MASK    = 8'h0C;
    localparam logic [7:0] FC_SUBTYPE_MASK = 8'hF0;
    localparam logic [7:0] FC_PROBE_REQ    = 8'h40;
    localparam logic [7:0] CHAR_LOW        = 8'h20;
    localparam logic [7:0] CHAR_HIGH       = 8'h7F;
    localparam logic [7:0] CHAR_DOT        = 8'h2E;
    localparam logic [5:0] WILD_LEN        = 6'd10;
    // "(Wildcard)", first character in the lowest byte
    localparam logic [79:0] WILD_TEXT = 80'h29_64_72_61_63_64_6C_69_57_28;

    typedef enum logic [1:0] {
        ACT_FRAME = 2'd0,
        ACT_READ  = 2'd1,
        ACT_CLEAR = 2'd2
    } action_t;

    typedef enum logic [2:0] {
        ST_IGNORED  = 3'd0,
        ST_UPDATED  = 3'd1,
        ST_INSERTED = 3'd2,
        ST_READ     = 3'd3,
        ST_CLEARED  = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        FSM_IDLE,
        FSM_COMPARE,
        FSM_APPLY
    } fsm_t;

    typedef struct packed {
        logic [47:0]          mac;
        logic [SSID_BITS-1:0] ssid;
        logic [5:0]           len;
        logic [7:0]           rssi;
        logic [31:0]          seen;
    } entry_t;

    typedef struct packed {
        logic clear;
        logic shift;
        logic update;
        logic compare;
    } cell_ctl_t;

    typedef struct packed {
        status_t     status;
        logic [4:0]  slot;
        logic [47:0] mac;
        logic [7:0]  rssi;
        logic [31:0] seen;
        logic [5:0]  len;
        logic [63:0] ssid;
        logic [5:0]  count;
        logic [31:0] probes;
    } result_t;

endpackage

// ===== sv/probe_request_tracker.sv =====
// top level of the probe request tracker: frame byte capture, sequencer,
// chain of prt_cell entries and result register; uses prt_pkg
//
// channel  dir  handshake           contents
// s_       in   s_tvalid/s_tready   one frame byte, read or clear request
// m_       out  m_tvalid/m_tready   one result per last byte, read or clear
//
// frame bytes that are not the last are captured while the sequencer stays idle
// the last byte of a frame passes through capture, parallel compare in every
// occupied cell, then update in place or a shift of the chain up to the first free cell by one slot
// read and clear requests are answered in the cycle after acceptance; clear acts on all cells at once
// reset is synchronous and empties the table; a stalled result holds
// the input also stalls while a result waits and m_tready is low
module probe_request_tracker #(
    parameter int TABLE_ENTRIES = prt_pkg::TABLE_ENTRIES_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // frame_byte, signal_strength, now_ms, entry_index, ssid_part, pad
    input  logic [55:0]  s_tdata,
    input  logic         s_tlast,
    // action, is_management
    input  logic [2:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // slot, station_mac, entry_rssi, last_seen_ms, ssid_length,
    // ssid_bytes, entry_count, probes_seen, pad
    output logic [207:0] m_tdata,
    // status
    output logic [2:0]   m_tuser
);

    localparam int IDX_W   = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int COUNT_W = $clog2(TABLE_ENTRIES + 1);
    localparam logic [COUNT_W-1:0] COUNT_MAX = COUNT_W'(TABLE_ENTRIES);

    // input fields
    logic [7:0]  in_byte, in_rssi;
    logic [31:0] in_now;
    logic [4:0]  in_index;
    logic [1:0]  in_part, in_action;
    logic        in_mgmt;
    assign in_byte   = s_tdata[7:0];
    assign in_rssi   = s_tdata[15:8];
    assign in_now    = s_tdata[47:16];
    assign in_index  = s_tdata[52:48];
    assign in_part   = s_tdata[54:53];
    assign in_action = s_tuser[1:0];
    assign in_mgmt   = s_tuser[2];

    prt_pkg::fsm_t state_reg, state_next;
    logic          accept;

    // frame capture registers
    logic [11:0]  pos_reg, pos_next;
    logic [7:0]   fc_reg, fc_next, sl_reg, sl_next;
    logic [47:0]  src_reg, src_next;
    logic [255:0] fssid_reg, fssid_next;

    // captured probe waiting for the cells
    logic            pr_ok_reg, pr_ok_next;
    logic [1:0]      pr_part_reg, pr_part_next;
    prt_pkg::entry_t pr_reg, pr_next;

    logic [COUNT_W-1:0] count_reg, count_next;
    logic [31:0]        probes_reg, probes_next;

    logic              out_valid_reg, out_valid_next;
    prt_pkg::result_t  out_reg, out_next;

    // cell chain
    prt_pkg::entry_t    cell_q [TABLE_ENTRIES];
    prt_pkg::entry_t    cell_in [TABLE_ENTRIES];
    prt_pkg::cell_ctl_t cell_ctl [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0] hits;

    logic             found;
    logic [IDX_W-1:0] hit_idx, sel_idx;
    prt_pkg::entry_t  sel_entry;

    // per-frame work signals
    logic [12:0] frame_len;
    logic [11:0] ssid_off;
    logic [4:0]  ssid_k;
    logic [7:0]  ssid_char;
    logic [5:0]  slen;
    logic        frame_ok;
    logic        idx_in_range;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == prt_pkg::FSM_IDLE) && (!out_valid_reg || m_tready);

    // first hit in the chain, lowest slot wins
    always_comb begin
        found   = 1'b0;
        hit_idx = '0;
        for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
            if (hits[i]) begin
                found   = 1'b1;
                hit_idx = IDX_W'(i);
            end
        end
    end

    assign idx_in_range = {2'b00, in_index} < 7'(TABLE_ENTRIES);
    assign sel_idx      = (state_reg == prt_pkg::FSM_APPLY) ? hit_idx : IDX_W'(in_index);
    assign sel_entry    = cell_q[sel_idx];

    // frame byte capture and end-of-frame check
    always_comb begin
        fc_next    = fc_reg;
        src_next   = src_reg;
        sl_next    = sl_reg;
        fssid_next = fssid_reg;
        pos_next   = pos_reg;
        ssid_off   = pos_reg - 12'(prt_pkg::HDR_LEN);
        ssid_k     = ssid_off[4:0];
        ssid_char  = (in_byte >= prt_pkg::CHAR_LOW && in_byte < prt_pkg::CHAR_HIGH) ?
                     in_byte : prt_pkg::CHAR_DOT;
        if (pos_reg == 12'd0) begin
            fc_next    = in_byte;
            src_next   = '0;
            sl_next    = '0;
            fssid_next = '0;
        end else if (pos_reg >= 12'd10 && pos_reg < 12'd16) begin
            src_next = {src_reg[39:0], in_byte};
        end else if (pos_reg == 12'd25) begin
            sl_next = in_byte;
        end else if (pos_reg >= 12'(prt_pkg::HDR_LEN) &&
                     pos_reg < 12'(prt_pkg::HDR_LEN + prt_pkg::SSID_MAX) &&
                     ssid_off < {4'b0000, sl_reg}) begin
            fssid_next[{ssid_k, 3'b000} +: 8] = fssid_reg[{ssid_k, 3'b000} +: 8] | ssid_char;
        end
        if (s_tlast) begin
            pos_next = '0;
        end else if (pos_reg < prt_pkg::POS_MAX) begin
            pos_next = pos_reg + 12'd1;
        end
        frame_len = {1'b0, pos_reg} + 13'd1;
        frame_ok  = in_mgmt && (frame_len >= 13'(prt_pkg::HDR_LEN)) &&
                    ((fc_next & prt_pkg::FC_TYPE_MASK) == 8'h00) &&
                    ((fc_next & prt_pkg::FC_SUBTYPE_MASK) == prt_pkg::FC_PROBE_REQ) &&
                    (13'(prt_pkg::HDR_LEN) + {5'b00000, sl_next} <= frame_len);
        slen = (sl_next > 8'(prt_pkg::SSID_MAX)) ? 6'(prt_pkg::SSID_MAX) : sl_next[5:0];
    end

    // sequencer, chain control and result assembly
    always_comb begin
        state_next     = state_reg;
        pr_ok_next     = pr_ok_reg;
        pr_part_next   = pr_part_reg;
        pr_next        = pr_reg;
        count_next     = count_reg;
        probes_next    = probes_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_next       = out_reg;
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            cell_ctl[i] = '0;
        end
        unique case (state_reg)
            prt_pkg::FSM_IDLE: begin
                if (accept) begin
                    case (in_action)
                        prt_pkg::ACT_FRAME: begin
                            if (s_tlast) begin
                                pr_ok_next   = frame_ok;
                                pr_part_next = in_part;
                                pr_next.mac  = src_next;
                                pr_next.rssi = in_rssi;
                                pr_next.seen = in_now;
                                if (slen == 6'd0) begin
                                    pr_next.ssid = {176'b0, prt_pkg::WILD_TEXT};
                                    pr_next.len  = prt_pkg::WILD_LEN;
                                end else begin
                                    pr_next.ssid = fssid_next;
                                    pr_next.len  = slen;
                                end
                                state_next = prt_pkg::FSM_COMPARE;
                            end
                        end
                        prt_pkg::ACT_READ: begin
                            out_valid_next  = 1'b1;
                            out_next        = '0;
                            out_next.status = prt_pkg::ST_READ;
                            out_next.slot   = in_index;
                            if (idx_in_range) begin
                                out_next.mac  = sel_entry.mac;
                                out_next.rssi = sel_entry.rssi;
                                out_next.seen = sel_entry.seen;
                                out_next.len  = sel_entry.len;
                                out_next.ssid = sel_entry.ssid[{in_part, 6'b000000} +: 64];
                            end
                            out_next.count  = 6'(count_reg);
                            out_next.probes = probes_reg;
                        end
                        prt_pkg::ACT_CLEAR: begin
                            for (int i = 0; i < TABLE_ENTRIES; i++) begin
                                cell_ctl[i].clear = 1'b1;
                            end
                            count_next      = '0;
                            probes_next     = '0;
                            out_valid_next  = 1'b1;
                            out_next        = '0;
                            out_next.status = prt_pkg::ST_CLEARED;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            prt_pkg::FSM_COMPARE: begin
                for (int i = 0; i < TABLE_ENTRIES; i++) begin
                    cell_ctl[i].compare = pr_ok_reg && (COUNT_W'(i) < count_reg);
                end
                state_next = prt_pkg::FSM_APPLY;
            end
            prt_pkg::FSM_APPLY: begin
                out_valid_next = 1'b1;
                out_next       = '0;
                if (pr_ok_reg) begin
                    probes_next = probes_reg + 32'd1;
                    if (found) begin
                        cell_ctl[hit_idx].update = 1'b1;
                        out_next.status = prt_pkg::ST_UPDATED;
                        out_next.slot   = 5'(hit_idx);
                        out_next.mac    = sel_entry.mac;
                        out_next.len    = sel_entry.len;
                        out_next.ssid   = sel_entry.ssid[{pr_part_reg, 6'b000000} +: 64];
                    end else begin
                        for (int i = 0; i < TABLE_ENTRIES; i++) begin
                            cell_ctl[i].shift = (COUNT_W'(i) <= count_reg);
                        end
                        if (count_reg < COUNT_MAX) begin
                            count_next = count_reg + COUNT_W'(1);
                        end
                        out_next.status = prt_pkg::ST_INSERTED;
                        out_next.mac    = pr_reg.mac;
                        out_next.len    = pr_reg.len;
                        out_next.ssid   = pr_reg.ssid[{pr_part_reg, 6'b000000} +: 64];
                    end
                    out_next.rssi = pr_reg.rssi;
                    out_next.seen = pr_reg.seen;
                end else begin
                    out_next.status = prt_pkg::ST_IGNORED;
                end
                out_next.count  = 6'(count_next);
                out_next.probes = probes_next;
                state_next      = prt_pkg::FSM_IDLE;
            end
            default: state_next = prt_pkg::FSM_IDLE;
        endcase
    end

    // state, counters and frame capture registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= prt_pkg::FSM_IDLE;
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
            probes_reg    <= '0;
            pos_reg       <= '0;
            fc_reg        <= '0;
            src_reg       <= '0;
            sl_reg        <= '0;
            fssid_reg     <= '0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            count_reg     <= count_next;
            probes_reg    <= probes_next;
            if (accept && in_action == prt_pkg::ACT_FRAME) begin
                pos_reg   <= pos_next;
                fc_reg    <= fc_next;
                src_reg   <= src_next;
                sl_reg    <= sl_next;
                fssid_reg <= fssid_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        out_reg     <= out_next;
        pr_reg      <= pr_next;
        pr_ok_reg   <= pr_ok_next;
        pr_part_reg <= pr_part_next;
    end

    // chain of entry cells, slot zero takes the new probe
    for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
        if (g == 0) begin : g_head
            assign cell_in[g] = pr_reg;
        end else begin : g_link
            assign cell_in[g] = cell_q[g-1];
        end
        prt_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .ctl      (cell_ctl[g]),
            .shift_in (cell_in[g]),
            .key      (pr_reg),
            .entry_q  (cell_q[g]),
            .hit      (hits[g])
        );
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.status;
    assign m_tdata  = {7'b0000000, out_reg.probes, out_reg.count, out_reg.ssid,
                       out_reg.len, out_reg.seen, out_reg.rssi, out_reg.mac, out_reg.slot};

endmodule

// ===== sv/prt_cell.sv =====
// one table cell: holds an entry, compares it against a probe key,
// and takes its neighbor's entry on a shift; uses prt_pkg
module prt_cell (
    input  logic              aclk,
    input  logic              aresetn,
    input  prt_pkg::cell_ctl_t ctl,
    input  prt_pkg::entry_t   shift_in,
    input  prt_pkg::entry_t   key,
    output prt_pkg::entry_t   entry_q,
    output logic              hit
);

    prt_pkg::entry_t entry_reg, entry_next;
    logic            hit_reg, hit_next;

    // entry update: clear, shift from neighbor, or refresh rssi and time
    always_comb begin
        entry_next = entry_reg;
        if (ctl.clear) begin
            entry_next = '0;
        end else if (ctl.shift) begin
            entry_next = shift_in;
        end else if (ctl.update) begin
            entry_next.rssi = key.rssi;
            entry_next.seen = key.seen;
        end
        hit_next = ctl.compare && (entry_reg.mac == key.mac) &&
                   (entry_reg.len == key.len) && (entry_reg.ssid == key.ssid);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_reg <= '0;
            hit_reg   <= 1'b0;
        end else begin
            entry_reg <= entry_next;
            hit_reg   <= hit_next;
        end
    end

    assign entry_q = entry_reg;
    assign hit     = hit_reg;

endmodule

// ===== sv/prt_checker.sv =====
// port-level checks for the probe request tracker, bound to the top level
// uses probe_request_tracker_defines.svh and prt_pkg
`include "probe_request_tracker_defines.svh"

module prt_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic [55:0]  s_tdata,
    input logic         s_tlast,
    input logic [2:0]   s_tuser,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [207:0] m_tdata,
    input logic [2:0]   m_tuser
);

    // a stalled result stays offered
    `PRT_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid)
    // a clear request answers in the next cycle
    `PRT_ASSERT_NEXT(a_clear, s_tvalid && s_tready && s_tuser[1:0] == prt_pkg::ACT_CLEAR, m_tvalid && m_tuser == prt_pkg::ST_CLEARED && m_tdata[200:163] == 38'd0)
    // ignored frames carry no entry
    `PRT_ASSERT_SAME(a_ignored, m_tvalid && m_tuser == prt_pkg::ST_IGNORED, m_tdata[162:0] == 163'd0)
    // no status beyond cleared
    `PRT_ASSERT_SAME(a_status, m_tvalid, m_tuser <= prt_pkg::ST_CLEARED)

endmodule

bind probe_request_tracker prt_checker u_prt_checker (.*);
